// ===== design/ifsxfe_pkg.sv =====
// Package for the frame sync, XOR check and field extract block.
// Holds header codes, frame layout constants, sequencer types and field tables.
// No dependencies.
package ifsxfe_pkg;

	localparam logic [7:0] HDR0 = 8'hBD;
	localparam logic [7:0] HDR1 = 8'hDB;
	localparam logic [7:0] HDR2 = 8'h0B;

	localparam int unsigned STORE_DEPTH = 54;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [5:0] STORE_BASE  = 6'd3;
	localparam logic [5:0] CHECK_POS   = 6'd57;
	localparam logic [4:0] FIELD_STATUS = 5'd15;
	localparam logic [4:0] FIELD_LAST   = 5'd16;
	localparam logic [3:0] ALIGN_MASK   = 4'hF;
	localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [4:0]        fld_t;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SEEN_BD,
		PH_SEEN_DB,
		PH_COLLECT
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_RUN,
		SEQ_FETCH,
		SEQ_CAPTURE,
		SEQ_EMIT
	} seq_t;

	// store address of the first byte of a field (frame offset minus header)
	function automatic addr_t fld_base(input fld_t k);
		addr_t a;
		case (k)
			5'd0:    a = 6'd0;
			5'd1:    a = 6'd2;
			5'd2:    a = 6'd4;
			5'd3:    a = 6'd6;
			5'd4:    a = 6'd8;
			5'd5:    a = 6'd10;
			5'd6:    a = 6'd12;
			5'd7:    a = 6'd14;
			5'd8:    a = 6'd16;
			5'd9:    a = 6'd18;
			5'd10:   a = 6'd22;
			5'd11:   a = 6'd26;
			5'd12:   a = 6'd30;
			5'd13:   a = 6'd32;
			5'd14:   a = 6'd34;
			5'd15:   a = 6'd36;
			5'd16:   a = 6'd49;
			default: a = 6'd0;
		endcase
		return a;
	endfunction

	// byte count of a field minus one
	function automatic logic [1:0] fld_len_m1(input fld_t k);
		logic [1:0] n;
		case (k)
			5'd9, 5'd10, 5'd11, 5'd16: n = 2'd3;
			5'd15:                     n = 2'd0;
			default:                   n = 2'd1;
		endcase
		return n;
	endfunction

endpackage

// ===== design/ifsxfe_in_if.sv =====
// Input channel: one received serial byte per item.
// Valid/ready handshake; no dependencies.
interface ifsxfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/ifsxfe_out_if.sv =====
// Result channel: one extracted frame field or one checksum error per item.
// Valid/ready handshake; no dependencies.
interface ifsxfe_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         field_index;
	logic signed [31:0] raw_value;
	logic               frame_ok;
	logic               aligned;
	logic               last;
	logic [31:0]        good_frames;
	logic [31:0]        bad_frames;

	modport source (output valid, output field_index, output raw_value, output frame_ok,
		output aligned, output last, output good_frames, output bad_frames, input ready);
	modport sink   (input valid, input field_index, input raw_value, input frame_ok,
		input aligned, input last, input good_frames, input bad_frames, output ready);
endinterface

// ===== design/ins_frame_sync_xor_field_extract_top.sv =====
// Frame sync, XOR check and raw field extraction, top level.
// Depends on ifsxfe_pkg, ifsxfe_in_if and ifsxfe_out_if.
//
// Usage:
//   rx carries one received byte per item. The block hunts for the header
//   BD DB 0B, stores frame bytes 3..56 in a 54-entry memory and keeps a
//   running XOR. rx stays ready after every byte that does not close a frame.
//   The closing byte (byte 57) is compared with the XOR. On a mismatch one
//   error item appears on res in the next cycle. On a match the 17 fields are
//   read back from the memory byte by byte through a single registered read
//   port and one byte assembler: the sequencer fetches each byte, captures it
//   into the assembler and, once the field is complete, offers it on res.
//   rx is not ready from the closing byte until the last item of the frame
//   has been taken; when res stalls, the current item holds in place and
//   the sequencer waits.
//   good_frames and bad_frames saturate at all ones.
//   Reset (arst_n low) returns to header hunt and clears both counts; the
//   frame memory is not cleared.
module ins_frame_sync_xor_field_extract_top (
	input  logic          clk,
	input  logic          arst_n,
	ifsxfe_in_if.sink     rx,
	ifsxfe_out_if.source  res
);
	import ifsxfe_pkg::*;

	phase_t      ph_q, ph_d;
	seq_t        seq_q, seq_d;
	logic [5:0]  pos_q, pos_d;
	logic [7:0]  xor_q, xor_d;
	logic [31:0] good_q, good_d;
	logic [31:0] bad_q, bad_d;
	fld_t        k_q, k_d;
	logic [1:0]  j_q, j_d;
	logic        err_q, err_d;
	logic [31:0] acc_q, acc_d;

	logic [7:0]  mem [STORE_DEPTH];
	logic [7:0]  rd_q;
	logic        wr_en;
	addr_t       wr_addr;
	addr_t       rd_addr;
	logic [1:0]  len_m1;
	logic [31:0] ext_val;

	assign wr_addr = ADDR_W'(pos_q - STORE_BASE);
	assign rd_addr = fld_base(k_q) + addr_t'(j_q);
	assign len_m1  = fld_len_m1(k_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= rx.rx_byte;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HUNT;
			seq_q  <= SEQ_RUN;
			pos_q  <= '0;
			xor_q  <= '0;
			good_q <= '0;
			bad_q  <= '0;
			k_q    <= '0;
			j_q    <= '0;
			err_q  <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			seq_q  <= seq_d;
			pos_q  <= pos_d;
			xor_q  <= xor_d;
			good_q <= good_d;
			bad_q  <= bad_d;
			k_q    <= k_d;
			j_q    <= j_d;
			err_q  <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	// next state
	always_comb begin
		ph_d   = ph_q;
		seq_d  = seq_q;
		pos_d  = pos_q;
		xor_d  = xor_q;
		good_d = good_q;
		bad_d  = bad_q;
		k_d    = k_q;
		j_d    = j_q;
		err_d  = err_q;
		acc_d  = acc_q;
		wr_en  = 1'b0;
		case (seq_q)
			SEQ_RUN: begin
				if (rx.valid) begin
					case (ph_q)
						PH_HUNT: begin
							if (rx.rx_byte == HDR0)
								ph_d = PH_SEEN_BD;
						end
						PH_SEEN_BD: begin
							if (rx.rx_byte == HDR1)
								ph_d = PH_SEEN_DB;
							else if (rx.rx_byte != HDR0)
								ph_d = PH_HUNT;
						end
						PH_SEEN_DB: begin
							if (rx.rx_byte == HDR2) begin
								ph_d  = PH_COLLECT;
								pos_d = STORE_BASE;
								xor_d = HDR0 ^ HDR1 ^ HDR2;
							end else if (rx.rx_byte == HDR0) begin
								ph_d = PH_SEEN_BD;
							end else begin
								ph_d = PH_HUNT;
							end
						end
						PH_COLLECT: begin
							if (pos_q != CHECK_POS) begin
								wr_en = 1'b1;
								xor_d = xor_q ^ rx.rx_byte;
								pos_d = pos_q + 6'd1;
							end else begin
								ph_d  = PH_HUNT;
								pos_d = '0;
								xor_d = '0;
								k_d   = '0;
								j_d   = '0;
								if (rx.rx_byte != xor_q) begin
									err_d = 1'b1;
									seq_d = SEQ_EMIT;
									if (bad_q != SAT32)
										bad_d = bad_q + 32'd1;
								end else begin
									err_d = 1'b0;
									seq_d = SEQ_FETCH;
									if (good_q != SAT32)
										good_d = good_q + 32'd1;
								end
							end
						end
						default: ph_d = PH_HUNT;
					endcase
				end
			end
			SEQ_FETCH: seq_d = SEQ_CAPTURE;
			SEQ_CAPTURE: begin
				acc_d[{j_q, 3'b000} +: 8] = rd_q;
				if (j_q == len_m1) begin
					seq_d = SEQ_EMIT;
				end else begin
					j_d   = j_q + 2'd1;
					seq_d = SEQ_FETCH;
				end
			end
			SEQ_EMIT: begin
				if (res.ready) begin
					if (err_q || k_q == FIELD_LAST) begin
						seq_d = SEQ_RUN;
					end else begin
						k_d   = k_q + 5'd1;
						j_d   = '0;
						seq_d = SEQ_FETCH;
					end
				end
			end
			default: seq_d = SEQ_RUN;
		endcase
	end

	// outputs
	always_comb begin
		case (len_m1)
			2'd0:    ext_val = {24'd0, acc_q[7:0]};
			2'd1:    ext_val = {{16{acc_q[15]}}, acc_q[15:0]};
			default: ext_val = acc_q;
		endcase
		rx.ready        = (seq_q == SEQ_RUN);
		res.valid       = (seq_q == SEQ_EMIT);
		res.field_index = err_q ? 5'd0 : k_q;
		res.raw_value   = err_q ? 32'sd0 : signed'(ext_val);
		res.frame_ok    = !err_q;
		res.aligned     = !err_q && (k_q == FIELD_STATUS) && (acc_q[3:0] == ALIGN_MASK);
		res.last        = err_q || (k_q == FIELD_LAST);
		res.good_frames = good_q;
		res.bad_frames  = bad_q;
	end

endmodule

// ===== dv/ifsxfe_frame_checker.sv =====
// Checker for the frame sync, XOR check and field extract block: follows the rx
// and res channels, predicts every field and error item and compares each one on arrival.
// Depends on ifsxfe_pkg, ifsxfe_in_if and ifsxfe_out_if.
module ifsxfe_frame_checker (
	input  logic  clk,
	input  logic  arst_n,
	ifsxfe_in_if  rx,
	ifsxfe_out_if res,
	output int    mismatches,
	output int    outstanding,
	output int    results_seen,
	output int    frames_good,
	output int    frames_bad
);
	import ifsxfe_pkg::*;

	localparam fld_t ERR_FIELD = 5'd0;

	// frame byte offset and byte count of each field
	localparam int FIELD_POS [17] = '{3, 5, 7, 9, 11, 13, 15, 17, 19, 21, 25, 29,
		33, 35, 37, 39, 52};
	localparam int FIELD_LEN [17] = '{2, 2, 2, 2, 2, 2, 2, 2, 2, 4, 4, 4,
		2, 2, 2, 1, 4};

	typedef struct packed {
		fld_t        idx;
		logic [31:0] val;
		logic        ok;
		logic        al;
		logic        lst;
		logic [31:0] good;
		logic [31:0] bad;
	} field_item_t;

	field_item_t expected_fields[$];

	phase_t      hunt_phase;
	logic [5:0]  frame_pos;
	logic [7:0]  run_xor;
	logic [7:0]  body [0:53];
	logic [31:0] good_total;
	logic [31:0] bad_total;

	task automatic absorb_rx_byte(input logic [7:0] b);
		field_item_t it;
		logic [31:0] v;
		int a;
		case (hunt_phase)
			PH_HUNT: begin
				if (b == HDR0)
					hunt_phase = PH_SEEN_BD;
			end
			PH_SEEN_BD: begin
				if (b == HDR1)
					hunt_phase = PH_SEEN_DB;
				else if (b != HDR0)
					hunt_phase = PH_HUNT;
			end
			PH_SEEN_DB: begin
				if (b == HDR2) begin
					hunt_phase = PH_COLLECT;
					frame_pos = STORE_BASE;
					run_xor = HDR0 ^ HDR1 ^ HDR2;
				end else begin
					hunt_phase = (b == HDR0) ? PH_SEEN_BD : PH_HUNT;
				end
			end
			default: begin
				if (frame_pos < CHECK_POS) begin
					body[frame_pos - STORE_BASE] = b;
					run_xor = run_xor ^ b;
					frame_pos = frame_pos + 6'd1;
				end else begin
					hunt_phase = PH_HUNT;
					frame_pos = '0;
					if (b != run_xor) begin
						if (bad_total != SAT32)
							bad_total = bad_total + 1;
						it = '{idx: ERR_FIELD, val: '0, ok: 1'b0, al: 1'b0, lst: 1'b1,
							good: good_total, bad: bad_total};
						expected_fields.insert(expected_fields.size(), it);
					end else begin
						if (good_total != SAT32)
							good_total = good_total + 1;
						for (int k = 0; k <= FIELD_LAST; k++) begin
							a = FIELD_POS[k] - STORE_BASE;
							case (FIELD_LEN[k])
								1: v = {24'd0, body[a]};
								2: v = {{16{body[a+1][7]}}, body[a+1], body[a]};
								default: v = {body[a+3], body[a+2], body[a+1], body[a]};
							endcase
							it.idx = fld_t'(k);
							it.val = v;
							it.ok = 1'b1;
							it.al = (k == FIELD_STATUS) && (v[3:0] == ALIGN_MASK);
							it.lst = (k == FIELD_LAST);
							it.good = good_total;
							it.bad = bad_total;
							expected_fields.insert(expected_fields.size(), it);
						end
					end
					run_xor = '0;
				end
			end
		endcase
	endtask

	task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		field_item_t it;
		if (expected_fields.size() == 0) begin
			$error("result with nothing pending: field_index %0d raw_value %0h",
				res.field_index, res.raw_value);
			mismatches++;
		end else begin
			it = expected_fields[0];
			expected_fields.delete(0);
			cmp("field_index", 32'(it.idx), 32'(res.field_index));
			cmp("raw_value", it.val, res.raw_value);
			cmp("frame_ok", 32'(it.ok), 32'(res.frame_ok));
			cmp("aligned", 32'(it.al), 32'(res.aligned));
			cmp("last", 32'(it.lst), 32'(res.last));
			cmp("good_frames", it.good, res.good_frames);
			cmp("bad_frames", it.bad, res.bad_frames);
			results_seen++;
			if (it.lst) begin
				if (it.ok)
					frames_good++;
				else
					frames_bad++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_phase = PH_HUNT;
			frame_pos = '0;
			run_xor = '0;
			good_total = '0;
			bad_total = '0;
			expected_fields.delete();
			outstanding <= 0;
		end else begin
			if (rx.valid && rx.ready)
				absorb_rx_byte(rx.rx_byte);
			if (res.valid && res.ready)
				check_result();
			outstanding <= expected_fields.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top: clock, reset, byte stimulus and result back-pressure for the
// frame sync block, with ifsxfe_frame_checker beside it for prediction and checking.
// Depends on ifsxfe_pkg, both channel interfaces, the top level and the checker.
module tb;
	import ifsxfe_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BYTES   = 60;
	localparam int SETTLE_CYCLES  = 50;
	localparam int FRAME_BYTES    = 58;

	localparam int PAT_ZERO    = 0;
	localparam int PAT_ONES    = 1;
	localparam int PAT_EXTREME = 2;
	localparam int PAT_RANDOM  = 3;

	logic clk;
	logic arst_n;

	ifsxfe_in_if  rx_ch ();
	ifsxfe_out_if res_ch ();

	int mismatches;
	int outstanding;
	int results_seen;
	int frames_good;
	int frames_bad;
	int hold_ask;
	int bytes_sent;
	bit tx_gaps;

	ins_frame_sync_xor_field_extract_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	ifsxfe_frame_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx_ch),
		.res          (res_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.frames_good  (frames_good),
		.frames_bad   (frames_bad)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_byte(input logic [7:0] b);
		int gap;
		int r;
		gap = 0;
		if (tx_gaps) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
	endtask

	task automatic send_frame(input int pattern, input bit corrupt, input int cut,
		input bit hold_on_check);
		logic [7:0] frm [FRAME_BYTES];
		logic [7:0] sum;
		frm[0] = HDR0;
		frm[1] = HDR1;
		frm[2] = HDR2;
		for (int i = 3; i < FRAME_BYTES - 1; i++) begin
			case (pattern)
				PAT_ZERO: frm[i] = 8'h00;
				PAT_ONES: frm[i] = 8'hFF;
				PAT_EXTREME: begin
					case ((i - 3) % 4)
						0: frm[i] = 8'h00;
						1: frm[i] = 8'h80;
						2: frm[i] = 8'hFF;
						default: frm[i] = 8'h7F;
					endcase
				end
				default: frm[i] = 8'($urandom_range(0, 255));
			endcase
		end
		if (pattern == PAT_EXTREME)
			frm[39] = 8'hFE;
		else if (pattern == PAT_RANDOM && $urandom_range(0, 1) == 1)
			frm[39][3:0] = ALIGN_MASK;
		sum = '0;
		for (int i = 0; i < FRAME_BYTES - 1; i++)
			sum = sum ^ frm[i];
		frm[FRAME_BYTES-1] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
		for (int i = 0; i < cut; i++) begin
			if (hold_on_check && i == FRAME_BYTES - 1)
				hold_ask <= hold_ask + 1;
			push_byte(frm[i]);
			bytes_sent++;
		end
	endtask

	task automatic send_noise(input int n);
		for (int j = 0; j < n; j++) begin
			case ($urandom_range(0, 3))
				0: push_byte(HDR0);
				1: push_byte(HDR1);
				2: push_byte(HDR2);
				default: push_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// result side: random stalls, mode changes, and a long hold on request
	initial begin
		int stall;
		int cyc;
		int holds_done;
		bit rx_stalls;
		stall = 0;
		cyc = 0;
		holds_done = 0;
		rx_stalls = 1'b1;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 300 == 0)
				rx_stalls = ($urandom_range(0, 3) != 0);
			if (hold_ask != holds_done) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				if (rx_stalls && $urandom_range(0, 99) < 30)
					stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
						: $urandom_range(15, 50);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		int r;
		int rand_start;
		int pattern;
		bit corrupt;
		bit held;
		bit paused;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		hold_ask = 0;
		bytes_sent = 0;
		tx_gaps = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// broken headers: stray codes, break after BD, break after BD DB, BD restarting
		push_byte(HDR2);
		push_byte(HDR1);
		push_byte(HDR0);
		push_byte(8'h00);
		push_byte(HDR0);
		push_byte(HDR1);
		push_byte(8'h55);
		push_byte(HDR0);
		push_byte(HDR1);
		push_byte(HDR0);
		send_frame(PAT_ZERO, 1'b0, FRAME_BYTES, 1'b0);
		push_byte(HDR0);
		send_frame(PAT_ONES, 1'b0, FRAME_BYTES, 1'b1);
		tx_gaps = 1'b1;
		send_frame(PAT_EXTREME, 1'b0, FRAME_BYTES, 1'b0);
		send_frame(PAT_RANDOM, 1'b1, FRAME_BYTES, 1'b0);
		send_frame(PAT_EXTREME, 1'b1, FRAME_BYTES, 1'b0);
		wait_drained();

		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RANDOM_BYTES) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_noise($urandom_range(1, 6));
			end else if (r < 20) begin
				send_frame(PAT_RANDOM, 1'b0, $urandom_range(3, FRAME_BYTES - 1), 1'b0);
			end else begin
				corrupt = ($urandom_range(0, 99) < 20);
				pattern = ($urandom_range(0, 9) < 8) ? PAT_RANDOM : $urandom_range(0, 2);
				send_frame(pattern, corrupt, FRAME_BYTES, !held && !corrupt);
				if (!corrupt)
					held = 1'b1;
			end
			if ($urandom_range(0, 9) == 0
				|| (!paused && bytes_sent - rand_start > RANDOM_BYTES / 2)) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("tb: %0d frame bytes sent, %0d field items checked", bytes_sent, results_seen);
		$display("tb: %0d good frames and %0d checksum errors seen", frames_good, frames_bad);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
